// File: rtl/hvtps_pkg.sv
// Package for the HV thermal unit power sequencer.
// Holds the state enum, payload and configuration structs, register indexes and constants.
// No dependencies.
`default_nettype none
package hvtps_pkg;

    typedef enum logic [2:0] {
        ST_SLEEP     = 3'd0,
        ST_WAKE      = 3'd1,
        ST_CLOSE     = 3'd2,
        ST_PRECHARGE = 3'd3,
        ST_OPERATE   = 3'd4,
        ST_WAITDOWN  = 3'd5,
        ST_POWEROFF  = 3'd6,
        ST_OPEN      = 3'd7
    } t_state;

    typedef enum logic [2:0] {
        REG_MIN_HV_VOLTAGE     = 3'd0,
        REG_WAKE_SETTLE_MS     = 3'd1,
        REG_CONTACTOR_CLOSE_MS = 3'd2,
        REG_PRECHARGE_LIMIT_MS = 3'd3,
        REG_SHUTDOWN_WAIT_MS   = 3'd4,
        REG_POWER_OFF_WAIT_MS  = 3'd5,
        REG_CONTACTOR_OPEN_MS  = 3'd6,
        REG_UNUSED             = 3'd7
    } t_reg_idx;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [15:0] RST_MIN_HV_VOLTAGE     = 16'd500;
    localparam logic [15:0] RST_WAKE_SETTLE_MS     = 16'd5000;
    localparam logic [15:0] RST_CONTACTOR_CLOSE_MS = 16'd100;
    localparam logic [15:0] RST_PRECHARGE_LIMIT_MS = 16'd30000;
    localparam logic [15:0] RST_SHUTDOWN_WAIT_MS   = 16'd1000;
    localparam logic [15:0] RST_POWER_OFF_WAIT_MS  = 16'd5000;
    localparam logic [15:0] RST_CONTACTOR_OPEN_MS  = 16'd300;

    localparam logic [15:0] SHUTDOWN_FAULT_HOLD_MS = 16'd2000;
    localparam logic [15:0] POWEROFF_FAULT_HOLD_MS = 16'd500;
    localparam logic [15:0] VOLT_INVALID           = 16'hFFFF;

    localparam logic [1:0] MODE_SELF_LOOP = 2'd1;
    localparam logic [1:0] REQ_INVALID    = 2'd3;

    localparam int unsigned FLT_WAKE      = 0;
    localparam int unsigned FLT_PRECHARGE = 1;
    localparam int unsigned FLT_UNIT      = 2;
    localparam int unsigned FLT_SHUTDOWN  = 3;
    localparam int unsigned FLT_POWEROFF  = 4;

    typedef struct packed {
        logic [15:0] min_hv_voltage;
        logic [15:0] wake_settle_ms;
        logic [15:0] contactor_close_ms;
        logic [15:0] precharge_limit_ms;
        logic [15:0] shutdown_wait_ms;
        logic [15:0] power_off_wait_ms;
        logic [15:0] contactor_open_ms;
    } t_cfg;

    typedef struct packed {
        logic [9:0]        elapsed_ms;
        logic              on_request;
        logic [15:0]       hv_reference;
        logic signed [7:0] temp_reference;
        logic [1:0]        mode_request;
        logic [1:0]        charging_request;
        logic [1:0]        fb_work_status;
        logic [1:0]        fb_relay_status;
        logic [1:0]        fb_fault_level;
        logic [5:0]        fb_fault_code;
    } t_in;

    typedef struct packed {
        logic [2:0]        seq_state;
        logic              wake_drive;
        logic              contactor_drive;
        logic [1:0]        sp_work_status;
        logic              sp_hv_request;
        logic              sp_relay;
        logic [1:0]        sp_charging;
        logic [15:0]       sp_hv_voltage;
        logic signed [7:0] sp_temperature;
        logic [4:0]        fault_flags;
    } t_out;

endpackage
`default_nettype wire

// File: rtl/hvtps_cfg.sv
// Configuration register bank of the power sequencer.
// Depends on hvtps_pkg for register indexes, reset values and the t_cfg struct.
`default_nettype none
module hvtps_cfg
    import hvtps_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_hv_voltage     <= RST_MIN_HV_VOLTAGE;
            r_cfg.wake_settle_ms     <= RST_WAKE_SETTLE_MS;
            r_cfg.contactor_close_ms <= RST_CONTACTOR_CLOSE_MS;
            r_cfg.precharge_limit_ms <= RST_PRECHARGE_LIMIT_MS;
            r_cfg.shutdown_wait_ms   <= RST_SHUTDOWN_WAIT_MS;
            r_cfg.power_off_wait_ms  <= RST_POWER_OFF_WAIT_MS;
            r_cfg.contactor_open_ms  <= RST_CONTACTOR_OPEN_MS;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_MIN_HV_VOLTAGE:     r_cfg.min_hv_voltage     <= i_cfg_data;
                REG_WAKE_SETTLE_MS:     r_cfg.wake_settle_ms     <= i_cfg_data;
                REG_CONTACTOR_CLOSE_MS: r_cfg.contactor_close_ms <= i_cfg_data;
                REG_PRECHARGE_LIMIT_MS: r_cfg.precharge_limit_ms <= i_cfg_data;
                REG_SHUTDOWN_WAIT_MS:   r_cfg.shutdown_wait_ms   <= i_cfg_data;
                REG_POWER_OFF_WAIT_MS:  r_cfg.power_off_wait_ms  <= i_cfg_data;
                REG_CONTACTOR_OPEN_MS:  r_cfg.contactor_open_ms  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// File: rtl/hvtps_core.sv
// Sequencer core: state machine, countdown timer, latched modes and sticky faults.
// Result is combinational from the registered step; state advances on i_step.
// Depends on hvtps_pkg.
`default_nettype none
module hvtps_core
    import hvtps_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_step,
    input  wire t_in  i_in,
    input  wire t_cfg i_cfg,
    output t_out      o_res
);

    t_state      r_state, n_state;
    logic [15:0] r_cd, n_cd;
    logic [1:0]  r_wm, n_wm;
    logic [1:0]  r_cm, n_cm;
    logic [4:0]  r_flt, n_flt;

    logic [15:0] cd_dec;
    logic        expired;
    logic [1:0]  wm_lat;
    logic        fb_any;
    logic        relay_closed;

    logic        wake, cont, hvreq, relay;
    logic [1:0]  ws, chg;
    logic [15:0] volt;

    always_comb begin
        cd_dec       = (r_cd > {6'd0, i_in.elapsed_ms}) ? (r_cd - {6'd0, i_in.elapsed_ms})
                                                        : 16'd0;
        expired      = (cd_dec == 16'd0);
        wm_lat       = (i_in.mode_request != REQ_INVALID) ? i_in.mode_request : r_wm;
        n_cm         = (i_in.charging_request != REQ_INVALID) ? i_in.charging_request : r_cm;
        relay_closed = (i_in.fb_relay_status != 2'd0);
        fb_any       = (i_in.fb_work_status != 2'd0) || relay_closed
                    || (i_in.fb_fault_level != 2'd0) || (i_in.fb_fault_code != 6'd0);
    end

    always_comb begin
        n_state = r_state;
        n_cd    = cd_dec;
        n_wm    = wm_lat;
        n_flt   = r_flt;
        unique case (r_state)
            ST_SLEEP: begin
                if (i_in.hv_reference >= i_cfg.min_hv_voltage && i_in.on_request) begin
                    n_cd    = i_cfg.wake_settle_ms;
                    n_state = ST_WAKE;
                end
            end
            ST_WAKE: begin
                if (expired) begin
                    if (fb_any) begin
                        n_state         = ST_SLEEP;
                        n_flt[FLT_WAKE] = 1'b1;
                    end else begin
                        n_cd    = i_cfg.contactor_close_ms;
                        n_state = ST_CLOSE;
                    end
                end
            end
            ST_CLOSE: begin
                if (expired) begin
                    n_cd    = i_cfg.precharge_limit_ms;
                    n_state = ST_PRECHARGE;
                end
            end
            ST_PRECHARGE: begin
                if (relay_closed) begin
                    n_wm    = MODE_SELF_LOOP;
                    n_state = ST_OPERATE;
                end else if (expired) begin
                    n_state              = ST_WAITDOWN;
                    n_flt[FLT_PRECHARGE] = 1'b1;
                end
            end
            ST_OPERATE: begin
                if (!i_in.on_request || i_in.fb_fault_level != 2'd0) begin
                    n_cd    = i_cfg.shutdown_wait_ms;
                    n_state = ST_WAITDOWN;
                end
                if (i_in.fb_fault_level != 2'd0) begin
                    n_flt[FLT_UNIT] = 1'b1;
                end
            end
            ST_WAITDOWN: begin
                if (i_in.fb_work_status == 2'd0) begin
                    n_cd    = i_cfg.power_off_wait_ms;
                    n_state = ST_POWEROFF;
                end else if (expired) begin
                    n_cd                = SHUTDOWN_FAULT_HOLD_MS;
                    n_flt[FLT_SHUTDOWN] = 1'b1;
                    n_state             = ST_POWEROFF;
                end
            end
            ST_POWEROFF: begin
                if (!relay_closed) begin
                    n_cd    = i_cfg.contactor_open_ms;
                    n_state = ST_OPEN;
                end else if (expired) begin
                    n_cd                = POWEROFF_FAULT_HOLD_MS;
                    n_flt[FLT_POWEROFF] = 1'b1;
                    n_state             = ST_OPEN;
                end
            end
            ST_OPEN: begin
                if (expired) begin
                    n_state = ST_SLEEP;
                end
            end
            default: begin
                n_state = ST_SLEEP;
            end
        endcase
    end

    always_comb begin
        wake  = 1'b1;
        cont  = 1'b1;
        ws    = 2'd0;
        hvreq = 1'b0;
        relay = 1'b0;
        chg   = 2'd0;
        volt  = VOLT_INVALID;
        unique case (r_state)
            ST_SLEEP: begin
                wake = 1'b0;
                cont = 1'b0;
            end
            ST_WAKE: begin
                cont = 1'b0;
            end
            ST_CLOSE: begin
            end
            ST_PRECHARGE, ST_WAITDOWN: begin
                hvreq = 1'b1;
                relay = 1'b1;
                volt  = i_in.hv_reference;
            end
            ST_OPERATE: begin
                ws    = wm_lat;
                hvreq = 1'b1;
                relay = 1'b1;
                chg   = n_cm;
                volt  = i_in.hv_reference;
            end
            ST_POWEROFF: begin
                relay = 1'b1;
                volt  = i_in.hv_reference;
            end
            ST_OPEN: begin
                cont = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_res.seq_state       = n_state;
        o_res.wake_drive      = wake;
        o_res.contactor_drive = cont;
        o_res.sp_work_status  = ws;
        o_res.sp_hv_request   = hvreq;
        o_res.sp_relay        = relay;
        o_res.sp_charging     = chg;
        o_res.sp_hv_voltage   = volt;
        o_res.sp_temperature  = i_in.temp_reference;
        o_res.fault_flags     = n_flt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SLEEP;
            r_cd    <= 16'd0;
            r_wm    <= 2'd0;
            r_cm    <= 2'd0;
            r_flt   <= 5'd0;
        end else if (i_step) begin
            r_state <= n_state;
            r_cd    <= n_cd;
            r_wm    <= n_wm;
            r_cm    <= n_cm;
            r_flt   <= n_flt;
        end
    end

endmodule
`default_nettype wire

// File: rtl/hv_thermal_unit_power_sequencer_unit.sv
// Top level of the HV thermal unit power sequencer: input register, core, result register.
// Depends on hvtps_pkg, hvtps_cfg and hvtps_core.
//
//   channel  direction  handshake                    payload
//   in       input      i_in_valid / o_in_ready      i_in_data  (t_in)
//   out      output     o_out_valid / i_out_ready    o_out_data (t_out)
//   cfg      input      i_cfg_we                     i_cfg_idx, i_cfg_data
//
// One step per cycle sustained while the result register is not stalled; a step is held in the
// input register and its result is then captured in the result register.
// The state machine advances when a step moves from the input register to the result register.
// A stalled result register holds the pending step in the input register; no step is lost.
// Reset is synchronous, active low; both registers start empty, state starts in sleep.
`default_nettype none
module hv_thermal_unit_power_sequencer_unit
    import hvtps_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in                   i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out                       o_out_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg cfg;
    t_in  r_in;
    logic r_in_valid;
    t_out r_out;
    logic r_out_valid;
    t_out res;
    logic step;

    assign step        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || step;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    hvtps_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    hvtps_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_in    (r_in),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= res;
        end
    end

endmodule
`default_nettype wire
